// ===== src/client_address_registry_table_unit_assert.svh =====
// assertion macros used by the scan control in carut_ctrl.sv
`ifndef CLIENT_ADDRESS_REGISTRY_TABLE_UNIT_ASSERT_SVH
`define CLIENT_ADDRESS_REGISTRY_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define CARUT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CARUT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/carut_pkg.sv =====
package carut_pkg;

   localparam int TABLE_SLOTS_DEF = 32;
   localparam int TABLE_SLOTS_MAX = 64;

   localparam int OP_W   = 2;
   localparam int UID_W  = 31;
   localparam int IP_W   = 32;
   localparam int PORT_W = 16;
   localparam int SLOT_W = 6;

   localparam int ENTRY_W = UID_W + IP_W + PORT_W;

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER  = 2'd0,
      OP_FETCH_ALL = 2'd1,
      OP_LOOKUP_ID = 2'd2,
      OP_LOOKUP_IP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_REG_ACK = 2'd0,
      KIND_ENTRY   = 2'd1,
      KIND_ID_ACK  = 2'd2,
      KIND_IP_ACK  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OUT_OK        = 2'd0,
      OUT_DUPLICATE = 2'd1,
      OUT_FULL      = 2'd2,
      OUT_NOT_FOUND = 2'd3
   } outcome_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   // one table slot as kept in the memory
   typedef struct packed {
      logic [UID_W-1:0]  user_id;
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
   } entry_type;

   // one result word
   typedef struct packed {
      kind_type          kind;
      outcome_type       outcome;
      logic [UID_W-1:0]  user_id;
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } rsp_type;

endpackage

// ===== src/carut_ram.sv =====
module carut_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/carut_store.sv =====
module carut_store
   import carut_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
   parameter int ADDR_W      = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_entry,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_entry
);

   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [TABLE_SLOTS-1:0] valid_in;
   logic                   rd_valid_ff;
   logic [ENTRY_W-1:0]     ram_q;

   carut_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (TABLE_SLOTS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // slots never written read as empty
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_entry = rd_valid_ff ? entry_type'(ram_q) : '0;

endmodule

// ===== src/carut_ctrl.sv =====
`include "client_address_registry_table_unit_assert.svh"

module carut_ctrl
   import carut_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
   parameter int ADDR_W      = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [UID_W-1:0]  req_client_id,
   input  logic [IP_W-1:0]   req_source_ip,
   input  logic [PORT_W-1:0] req_listen_port,
   input  logic [UID_W-1:0]  req_query_user_id,
   input  logic [IP_W-1:0]   req_query_ip,
   output logic              busy,
   output logic [ADDR_W-1:0] rd_addr,
   input  entry_type         rd_entry,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output entry_type         wr_entry,
   output logic              rsp_fire,
   output rsp_type           rsp_word
);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   op_type            op_ff;
   logic [UID_W-1:0]  uid_ff;
   logic [IP_W-1:0]   sip_ff;
   logic [PORT_W-1:0] port_ff;
   logic [UID_W-1:0]  quid_ff;
   logic [IP_W-1:0]   qip_ff;
   logic              accept;
   logic              is_last;
   logic              done;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign is_last = (idx_ff == ADDR_W'(TABLE_SLOTS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_operation);
         uid_ff  <= req_client_id;
         sip_ff  <= req_source_ip;
         port_ff <= req_listen_port;
         quid_ff <= req_query_user_id;
         qip_ff  <= req_query_ip;
      end
   end

   assign wr_addr  = idx_ff;
   assign wr_entry = '{user_id: uid_ff, ip: sip_ff, port: port_ff};

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rd_addr  = '0;
      wr_en    = 1'b0;
      rsp_fire = 1'b0;
      done     = 1'b0;
      rsp_word = '{kind: kind_type'(op_ff), outcome: OUT_OK, user_id: uid_ff,
                   ip: sip_ff, port: '0, slot: SLOT_W'(idx_ff), last: 1'b1};
      case (state_ff)
         ST_IDLE: begin
            // slot 0 is read while idle so it is ready after accept
            idx_in = '0;
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_addr = is_last ? '0 : idx_ff + 1'b1;
            case (op_ff)
               OP_REGISTER: begin
                  if (rd_entry.user_id == uid_ff) begin
                     rsp_fire         = 1'b1;
                     rsp_word.outcome = OUT_DUPLICATE;
                  end else if (rd_entry.user_id == '0) begin
                     wr_en    = 1'b1;
                     rsp_fire = 1'b1;
                  end else if (is_last) begin
                     rsp_fire         = 1'b1;
                     rsp_word.outcome = OUT_FULL;
                     rsp_word.slot    = '0;
                  end
               end
               OP_FETCH_ALL: begin
                  rsp_fire         = 1'b1;
                  rsp_word.user_id = rd_entry.user_id;
                  rsp_word.ip      = rd_entry.ip;
                  rsp_word.port    = rd_entry.port;
                  rsp_word.last    = is_last;
               end
               OP_LOOKUP_ID: begin
                  rsp_word.user_id = quid_ff;
                  if (rd_entry.user_id != '0 && rd_entry.user_id == quid_ff) begin
                     rsp_fire      = 1'b1;
                     rsp_word.ip   = rd_entry.ip;
                     rsp_word.port = rd_entry.port;
                  end else if (is_last) begin
                     rsp_fire         = 1'b1;
                     rsp_word.outcome = OUT_NOT_FOUND;
                     rsp_word.ip      = '0;
                     rsp_word.slot    = '0;
                  end
               end
               default: begin
                  rsp_word.ip = qip_ff;
                  if (rd_entry.user_id != '0 && rd_entry.ip == qip_ff) begin
                     rsp_fire         = 1'b1;
                     rsp_word.user_id = rd_entry.user_id;
                     rsp_word.port    = rd_entry.port;
                  end else if (is_last) begin
                     rsp_fire         = 1'b1;
                     rsp_word.outcome = OUT_NOT_FOUND;
                     rsp_word.user_id = '0;
                     rsp_word.slot    = '0;
                  end
               end
            endcase
            done   = rsp_fire && rsp_word.last;
            idx_in = idx_ff + 1'b1;
            if (done) begin
               state_in = ST_IDLE;
               idx_in   = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            idx_in   = '0;
         end
      endcase
   end

   `CARUT_ASSERT_NOW(a_wr_only_on_register, wr_en, (state_ff == ST_SCAN) && (op_ff == OP_REGISTER) && rsp_fire, "memory write outside a register scan")
   `CARUT_ASSERT_NEXT(a_single_write, wr_en, !wr_en, "more than one write for one request")
   `CARUT_ASSERT_NEXT(a_last_ends_scan, rsp_fire && rsp_word.last, state_ff == ST_IDLE, "scan continues after final word")
   `CARUT_ASSERT_NEXT(a_accept_starts_at_zero, accept, (state_ff == ST_SCAN) && (idx_ff == '0), "scan does not start at slot zero")

endmodule

// ===== src/client_address_registry_table_unit.sv =====
// response: a register or lookup word is registered out after the slot that decides it,
//    or after the last slot on a miss or full table; fetch all gives TABLE_SLOTS words on
//    consecutive cycles
// throughput: a new request is taken only once the scan for the last one has ended, set by
//    the single memory read port that scans one slot a cycle; words cannot be held off
// reset: synchronous; per-slot valid bits clear at once so every slot reads empty, no sweep
module client_address_registry_table_unit
   import carut_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,

   // request channel
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [UID_W-1:0]  req_client_id,
   input  logic [IP_W-1:0]   req_source_ip,
   input  logic [PORT_W-1:0] req_listen_port,
   input  logic [UID_W-1:0]  req_query_user_id,
   input  logic [IP_W-1:0]   req_query_ip,

   // response channel
   output logic              rsp_strobe,
   output logic [1:0]        rsp_reply_kind,
   output logic [1:0]        rsp_outcome,
   output logic [UID_W-1:0]  rsp_reply_user_id,
   output logic [IP_W-1:0]   rsp_reply_ip,
   output logic [PORT_W-1:0] rsp_reply_port,
   output logic [SLOT_W-1:0] rsp_slot_index,
   output logic              rsp_last
);

   // slot address width, at least one bit for a single-slot table
   localparam int ADDR_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

   // memory access between scan control and the slot store
   logic [ADDR_W-1:0] rd_addr;
   entry_type         rd_entry;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_entry;

   // word decided in the current scan cycle
   logic    rsp_fire;
   rsp_type rsp_word;

   // output register, one word per strobe
   logic    rsp_valid_ff;
   rsp_type rsp_word_ff;

   // slot store: one memory row per slot plus valid bits
   carut_store #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .ADDR_W      (ADDR_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   // request sequencer: walks the slots and decides each word
   carut_ctrl #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_operation     (req_operation),
      .req_client_id     (req_client_id),
      .req_source_ip     (req_source_ip),
      .req_listen_port   (req_listen_port),
      .req_query_user_id (req_query_user_id),
      .req_query_ip      (req_query_ip),
      .busy              (busy),
      .rd_addr           (rd_addr),
      .rd_entry          (rd_entry),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_entry          (wr_entry),
      .rsp_fire          (rsp_fire),
      .rsp_word          (rsp_word)
   );

   // strobe needs reset, the payload only follows it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         rsp_word_ff <= rsp_word;
      end
   end

   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_reply_kind    = rsp_word_ff.kind;
   assign rsp_outcome       = rsp_word_ff.outcome;
   assign rsp_reply_user_id = rsp_word_ff.user_id;
   assign rsp_reply_ip      = rsp_word_ff.ip;
   assign rsp_reply_port    = rsp_word_ff.port;
   assign rsp_slot_index    = rsp_word_ff.slot;
   assign rsp_last          = rsp_word_ff.last;

endmodule
